[rtl/camera_pixel_normalize_transmission_unit_assert.svh]
// Assertion macros used by the checker of the pixel normalizer.
`ifndef CAMERA_PIXEL_NORMALIZE_TRANSMISSION_UNIT_ASSERT_SVH
`define CAMERA_PIXEL_NORMALIZE_TRANSMISSION_UNIT_ASSERT_SVH

// A property that must hold at every rising clock edge outside reset.
`define CPNT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define CPNT_ASSERT_NEXT(label, cond, expect_nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (cond) |=> (expect_nxt)) else $error(msg);

`endif

[rtl/cpnt_pkg.sv]
// Types, constants and helpers shared by the pixel normalizer modules.
`timescale 1ns / 1ps
package cpnt_pkg;

  // Field widths on the channels.
  localparam int FIELD_W     = 16;
  localparam int GRAY_W      = 8;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 3 * FIELD_W;
  localparam int OUT_TDATA_W = 4 * GRAY_W;

  // Divider lanes: three gray levels and the transmission ratio.
  localparam int NUM_GRAY   = 3;
  localparam int NUM_LANES  = NUM_GRAY + 1;
  localparam int LANE_TRANS = NUM_GRAY;

  // The ratio is (d0 << 16) / d1, clamped below 2 << 16 and shifted right by 9.
  // That equals (d0 << 7) / d1 saturated to eight bits.
  localparam int RATIO_FRAC  = 16;
  localparam int RATIO_SHIFT = 9;
  localparam int TRANS_SHIFT = RATIO_FRAC - RATIO_SHIFT;

  // Every quotient is eight bits plus one overflow bit that saturates it.
  localparam int QUO_W     = GRAY_W + 1;
  localparam int DEN_W     = 16;
  localparam int REM_W     = DEN_W + GRAY_W;
  localparam int NUM_CELLS = QUO_W;

  localparam logic [GRAY_W-1:0] GRAY_MAX    = '1;
  localparam logic [1:0]        LAYERS_ONE  = 2'd1;
  localparam logic [1:0]        LAYERS_TWO  = 2'd2;
  localparam logic [1:0]        LAYERS_FULL = 2'd3;
  localparam logic [DEN_W-1:0]  MAX_RESET   = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAYER_COUNT = 2'd0,
    REG_MAX_A       = 2'd1,
    REG_MAX_B       = 2'd2,
    REG_MAX_C       = 2'd3
  } reg_idx_t;

  // One restoring-division lane.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } lane_t;

  // Payload carried from cell to cell.
  typedef struct packed {
    logic [NUM_GRAY-1:0]       gray_en;
    logic                      trans_en;
    lane_t [NUM_LANES-1:0]     lane;
  } stage_t;

  // Saturate a nine-bit quotient to eight bits.
  function automatic logic [GRAY_W-1:0] sat_quo(input logic [QUO_W-1:0] quo);
    return quo[QUO_W-1] ? GRAY_MAX : quo[GRAY_W-1:0];
  endfunction

endpackage

[rtl/cpnt_front.sv]
// Input stage: masks counts, picks active layers and loads the divider lanes.
`timescale 1ns / 1ps
module cpnt_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         load,
  input  logic                                         in_vld,
  input  logic [cpnt_pkg::FIELD_W-1:0]                 count_a,
  input  logic [cpnt_pkg::FIELD_W-1:0]                 count_b,
  input  logic [cpnt_pkg::FIELD_W-1:0]                 count_c,
  input  logic [1:0]                                   layer_count,
  input  logic [cpnt_pkg::NUM_GRAY-1:0][cpnt_pkg::DEN_W-1:0] max_value,
  output logic                                         vld_r,
  output cpnt_pkg::stage_t                             pay_r
);
  import cpnt_pkg::*;

  logic [NUM_GRAY-1:0][COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0]               dif_lit;
  logic [COUNT_BITS-1:0]               dif_ref;
  logic [1:0]                          layers;
  stage_t                              pay_nxt;

  // Counts are taken in their low bits only.
  assign cnt[0]  = count_a[COUNT_BITS-1:0];
  assign cnt[1]  = count_b[COUNT_BITS-1:0];
  assign cnt[2]  = count_c[COUNT_BITS-1:0];
  assign dif_lit = cnt[0] - cnt[2];
  assign dif_ref = cnt[1] - cnt[2];

  // A layer count of zero means a single layer.
  assign layers = (layer_count == 2'd0) ? LAYERS_ONE : layer_count;

  // Gray lanes: numerator 255 * count, denominator the layer maximum forced to at least one.
  always_comb begin
    pay_nxt = '0;
    pay_nxt.gray_en[0] = 1'b1;
    pay_nxt.gray_en[1] = (layers >= LAYERS_TWO);
    pay_nxt.gray_en[2] = (layers == LAYERS_FULL);
    pay_nxt.trans_en   = (layers == LAYERS_FULL) && (cnt[0] > cnt[2]) && (cnt[1] > cnt[2]);
    for (int l = 0; l < NUM_GRAY; l++) begin
      pay_nxt.lane[l].rem = (REM_W'(cnt[l]) << GRAY_W) - REM_W'(cnt[l]);
      pay_nxt.lane[l].den = (max_value[l] == '0) ? DEN_W'(1) : max_value[l];
      pay_nxt.lane[l].quo = '0;
    end
    pay_nxt.lane[LANE_TRANS].rem = REM_W'(dif_lit) << TRANS_SHIFT;
    pay_nxt.lane[LANE_TRANS].den = DEN_W'(dif_ref);
    pay_nxt.lane[LANE_TRANS].quo = '0;
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= in_vld;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      pay_r <= pay_nxt;
    end
  end

endmodule

[rtl/cpnt_cell.sv]
// One divider cell: develops one quotient bit in each of the four lanes.
`timescale 1ns / 1ps
module cpnt_cell #(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             prev_vld,
  input  cpnt_pkg::stage_t prev_pay,
  output logic             vld_r,
  output cpnt_pkg::stage_t pay_r
);
  import cpnt_pkg::*;

  stage_t pay_nxt;

  // Restoring step: subtract the shifted divisor where it fits.
  always_comb begin
    logic [REM_W-1:0] den_sh;
    logic             fit;
    pay_nxt = prev_pay;
    for (int l = 0; l < NUM_LANES; l++) begin
      den_sh = REM_W'(prev_pay.lane[l].den) << BIT;
      fit    = (prev_pay.lane[l].rem >= den_sh);
      if (fit) begin
        pay_nxt.lane[l].rem = prev_pay.lane[l].rem - den_sh;
      end
      pay_nxt.lane[l].quo = {prev_pay.lane[l].quo[QUO_W-2:0], fit};
    end
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= prev_vld;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      pay_r <= pay_nxt;
    end
  end

endmodule

[rtl/camera_pixel_normalize_transmission_unit.sv]
// Top level of the camera pixel normalizer with transmission ratio.
//
// Usage:
//   in_*   : one pixel per transfer; in_tdata holds count_a, count_b, count_c.
//   out_*  : one result per pixel, in order; out_tdata holds gray_a, gray_b,
//            gray_c and transmission, out_tuser the transmission valid flag.
//   cfg_*  : register writes (layer count, three maxima), idle-only by user rule, not enforced.
//   Each gray level is 255 * count / max saturated at 255. With three layers
//   and both lit counts above the dark count, transmission is the ratio
//   (count_a - count_c) / (count_b - count_c) scaled so that 128 means equal.
//   A pixel transferred on in_* is loaded into the front stage and passes
//   through nine divider cells before it is shown on out_*, each adding one
//   register stage, one cell per quotient bit. Throughput is one pixel per
//   cycle while the receiver keeps out_tready high.
//   Reset empties the pipeline and loads the register defaults (three layers,
//   all maxima 65535).
//   When the receiver stalls, the chain keeps moving into empty stages and
//   in_tready stays high until every stage holds a pixel.
`timescale 1ns / 1ps
module camera_pixel_normalize_transmission_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cpnt_pkg::IN_TDATA_W-1:0]     in_tdata,   // count_a, count_b, count_c
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cpnt_pkg::OUT_TDATA_W-1:0]    out_tdata,  // gray_a, gray_b, gray_c, transmission
  output logic [0:0]                          out_tuser,  // transmission_valid
  // Configuration writes.
  input  logic                                cfg_we,
  input  logic [cpnt_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [cpnt_pkg::CFG_W-1:0]          cfg_wdata
);
  import cpnt_pkg::*;

  logic [1:0]                        layer_count_r;
  logic [1:0]                        layer_count_nxt;
  logic [NUM_GRAY-1:0][DEN_W-1:0]    max_value_r;
  logic [NUM_GRAY-1:0][DEN_W-1:0]    max_value_nxt;

  logic   vld [NUM_CELLS+1];
  stage_t pay [NUM_CELLS+1];
  logic   rdy [NUM_CELLS+1];
  stage_t last;

  // Configuration registers.
  always_comb begin
    layer_count_nxt = layer_count_r;
    max_value_nxt   = max_value_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_LAYER_COUNT: layer_count_nxt  = cfg_wdata[1:0];
        REG_MAX_A:       max_value_nxt[0] = cfg_wdata[DEN_W-1:0];
        REG_MAX_B:       max_value_nxt[1] = cfg_wdata[DEN_W-1:0];
        REG_MAX_C:       max_value_nxt[2] = cfg_wdata[DEN_W-1:0];
        default:         layer_count_nxt  = layer_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r <= LAYERS_FULL;
      max_value_r   <= {NUM_GRAY{MAX_RESET}};
    end else begin
      layer_count_r <= layer_count_nxt;
      max_value_r   <= max_value_nxt;
    end
  end

  // A stage moves when it is empty or the stage after it moves.
  assign rdy[NUM_CELLS] = !vld[NUM_CELLS] || out_tready;
  for (genvar s = 0; s < NUM_CELLS; s++) begin : g_rdy
    assign rdy[s] = !vld[s] || rdy[s+1];
  end
  assign in_tready = rdy[0];

  // Front stage.
  cpnt_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (rdy[0]),
    .in_vld      (in_tvalid),
    .count_a     (in_tdata[FIELD_W-1:0]),
    .count_b     (in_tdata[2*FIELD_W-1:FIELD_W]),
    .count_c     (in_tdata[3*FIELD_W-1:2*FIELD_W]),
    .layer_count (layer_count_r),
    .max_value   (max_value_r),
    .vld_r       (vld[0]),
    .pay_r       (pay[0])
  );

  // Divider chain, most significant quotient bit first.
  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    cpnt_cell #(
      .BIT (NUM_CELLS - 1 - c)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (rdy[c+1]),
      .prev_vld (vld[c]),
      .prev_pay (pay[c]),
      .vld_r    (vld[c+1]),
      .pay_r    (pay[c+1])
    );
  end

  // Result formatting from the last cell.
  assign last       = pay[NUM_CELLS];
  assign out_tvalid = vld[NUM_CELLS];
  always_comb begin
    for (int l = 0; l < NUM_GRAY; l++) begin
      out_tdata[l*GRAY_W +: GRAY_W] = last.gray_en[l] ? sat_quo(last.lane[l].quo) : '0;
    end
    out_tdata[LANE_TRANS*GRAY_W +: GRAY_W] =
      last.trans_en ? sat_quo(last.lane[LANE_TRANS].quo) : '0;
  end
  assign out_tuser[0] = last.trans_en;

endmodule

[rtl/cpnt_checker.sv]
// Port checker for the pixel normalizer and its bind to the top level.
`timescale 1ns / 1ps
`include "camera_pixel_normalize_transmission_unit_assert.svh"
module cpnt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [cpnt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [0:0]                         out_tuser
);
  import cpnt_pkg::*;

  // A stalled result holds its value.
  `CPNT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // Without a valid ratio the transmission field reads zero.
  `CPNT_ASSERT(a_trans_zero, !(out_tvalid && !out_tuser[0]) || (out_tdata[OUT_TDATA_W-1 -: GRAY_W] == '0), "transmission set without valid flag")

  // The chain can only fill up behind a stalled output.
  `CPNT_ASSERT(a_ready_fill, in_tready || (out_tvalid && !out_tready), "input stalled while output drains")

endmodule

bind camera_pixel_normalize_transmission_unit cpnt_checker u_cpnt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[dv/testbench.sv]
// Self-checking bench for the pixel normalizer and its transmission ratio.
`timescale 1ns / 1ps
module testbench;
  import cpnt_pkg::*;

  localparam int DIR_ROWS = 16;
  localparam int PHASES = 12;
  localparam int PIXELS_PER_PHASE = 100;
  localparam int STEADY_PHASE = 4;
  localparam int IDLE_PERCENT = 7;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [31:0] RATIO_LIMIT = 32'd2 << RATIO_FRAC;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;

  // One result: three gray levels, the ratio and its valid flag.
  typedef struct packed {
    logic [GRAY_W-1:0] gray_a;
    logic [GRAY_W-1:0] gray_b;
    logic [GRAY_W-1:0] gray_c;
    logic [GRAY_W-1:0] transmission;
    logic              trans_valid;
  } pixel_result_t;

  // One row of the directed table; typed rows carry their result.
  typedef struct {
    logic [FIELD_W-1:0] ca;
    logic [FIELD_W-1:0] cb;
    logic [FIELD_W-1:0] cc;
    bit                 typed;
    pixel_result_t      want;
  } pixel_case_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic [0:0]              out_tuser;
  logic                    cfg_we = 1'b0;
  reg_idx_t                cfg_addr = REG_LAYER_COUNT;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  // Register copies, matching the reset defaults of the block.
  logic [1:0]              active_layers = LAYERS_FULL;
  logic [DEN_W-1:0]        max_a = MAX_RESET;
  logic [DEN_W-1:0]        max_b = MAX_RESET;
  logic [DEN_W-1:0]        max_c = MAX_RESET;

  pixel_result_t           normalized_pixels [$];
  int                      bad_fields = 0;
  bit                      steady = 1'b0;

  camera_pixel_normalize_transmission_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gray level of one layer: 255 * count / max, a zero maximum taken as 1.
  function automatic logic [GRAY_W-1:0] gray_level(input logic [FIELD_W-1:0] count,
                                                   input logic [DEN_W-1:0] maxv);
    logic [31:0] q;
    q = (32'(GRAY_MAX) * count) / ((maxv == '0) ? 32'd1 : 32'(maxv));
    return (q > 32'(GRAY_MAX)) ? GRAY_MAX : q[GRAY_W-1:0];
  endfunction

  // Result of one pixel under the current register settings.
  function automatic pixel_result_t normalize_pixel(input logic [FIELD_W-1:0] ca,
                                                    input logic [FIELD_W-1:0] cb,
                                                    input logic [FIELD_W-1:0] cc);
    logic [1:0]    layers;
    logic [31:0]   ratio;
    logic [15:0]   lit_a;
    pixel_result_t r;
    layers = (active_layers == 2'd0) ? LAYERS_ONE : active_layers;
    r = '0;
    r.gray_a = gray_level(ca, max_a);
    if (layers >= LAYERS_TWO) r.gray_b = gray_level(cb, max_b);
    if (layers == LAYERS_FULL) r.gray_c = gray_level(cc, max_c);
    if (layers == LAYERS_FULL && ca > cc && cb > cc) begin
      lit_a = ca - cc;
      ratio = {lit_a, 16'h0000} / 32'(cb - cc);
      if (ratio >= RATIO_LIMIT) ratio = RATIO_LIMIT - 32'd1;
      ratio = ratio >> RATIO_SHIFT;
      r.transmission = ratio[GRAY_W-1:0];
      r.trans_valid = 1'b1;
    end
    return r;
  endfunction

  // Maximum for a random phase: zero, small, large or full scale.
  function automatic logic [DEN_W-1:0] pick_max();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 16'($urandom_range(1, 255));
      2: return COUNT_TOP;
      default: return 16'($urandom_range(256, 65535));
    endcase
  endfunction

  // Count at or below a layer maximum, or close to it, so both sides of saturation are hit.
  function automatic logic [FIELD_W-1:0] near_max(input logic [DEN_W-1:0] maxv);
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, maxv));
    return 16'(maxv + $urandom_range(0, 4) - 2);
  endfunction

  // Random pixel: mostly lit-over-dark triples, then noise, saturation and edges.
  function automatic logic [IN_TDATA_W-1:0] draw_pixel();
    logic [FIELD_W-1:0] ca, cb, cc;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      cc = 16'($urandom_range(0, $urandom_range(0, 1) ? 2000 : 65534));
      case ($urandom_range(0, 3))
        0: cb = 16'(cc + $urandom_range(1, 8));
        default: cb = 16'($urandom_range(cc + 1, 65535));
      endcase
      case ($urandom_range(0, 3))
        0: ca = 16'($urandom_range(cb > 16'd4 ? cb - 4 : cc + 1, cb + 4));
        1: ca = 16'($urandom_range(cc + 1, cc + 64));
        default: ca = 16'($urandom_range(cc + 1, 65535));
      endcase
      if (ca <= cc) ca = cc + 16'd1;
    end else if (pick < 75) begin
      ca = 16'($urandom);
      cb = 16'($urandom);
      cc = 16'($urandom);
    end else if (pick < 90) begin
      ca = near_max(max_a);
      cb = near_max(max_b);
      cc = near_max(max_c);
    end else begin
      ca = $urandom_range(0, 1) ? COUNT_TOP : 16'h0000;
      cb = $urandom_range(0, 1) ? COUNT_TOP : 16'h0000;
      cc = 16'($urandom);
      case ($urandom_range(0, 2))
        0: ca = cc;
        1: cb = cc;
        default: ;
      endcase
    end
    return {cc, cb, ca};
  endfunction

  // Write one register, keeping the local copy in step.
  task automatic write_register(input reg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_LAYER_COUNT: active_layers = value[1:0];
      REG_MAX_A:       max_a = value;
      REG_MAX_B:       max_b = value;
      REG_MAX_C:       max_c = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Load all four registers; junk above the layer field must be ignored.
  task automatic apply_settings(input logic [1:0] layers, input logic [DEN_W-1:0] ma,
                                input logic [DEN_W-1:0] mb, input logic [DEN_W-1:0] mc);
    write_register(REG_LAYER_COUNT, {14'($urandom), layers});
    write_register(REG_MAX_A, ma);
    write_register(REG_MAX_B, mb);
    write_register(REG_MAX_C, mc);
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel from a falling edge; record its result once transferred.
  task automatic send_pixel(input logic [IN_TDATA_W-1:0] pixel, input pixel_result_t want);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pixel;
    do @(posedge clk); while (!in_tready);
    normalized_pixels.push_back(want);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [GRAY_W-1:0] want,
                             input logic [GRAY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_fields++;
    end
  endtask

  // Receiver backpressure, changed on the falling edge.
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Compare each result transfer with the oldest outstanding pixel.
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (normalized_pixels.size() == 0) begin
        $error("result transfer with no pixel outstanding: tdata %h", out_tdata);
        bad_fields++;
      end else begin
        want = normalized_pixels.pop_front();
        check_field("gray_a", want.gray_a, out_tdata[GRAY_W-1:0]);
        check_field("gray_b", want.gray_b, out_tdata[2*GRAY_W-1:GRAY_W]);
        check_field("gray_c", want.gray_c, out_tdata[3*GRAY_W-1:2*GRAY_W]);
        check_field("transmission", want.transmission, out_tdata[4*GRAY_W-1:3*GRAY_W]);
        check_field("transmission_valid", 8'(want.trans_valid), 8'(out_tuser[0]));
      end
    end
  end

  // Directed pixels, reset settings, then random phases through many settings.
  initial begin
    pixel_case_t   dir_cases [DIR_ROWS];
    pixel_result_t want;
    dir_cases = '{
      // All dark and all full scale: no ratio since lit equals dark.
      '{16'h0000, 16'h0000, 16'h0000, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0}},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd0,   1'b0}},
      // Equal lit counts give 128; a tiny reference clamps to 255.
      '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, '{8'd255, 8'd255, 8'd0,   8'd128, 1'b1}},
      '{16'hFFFF, 16'h0001, 16'h0000, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd255, 1'b1}},
      '{16'h0001, 16'hFFFF, 16'h0000, 1'b1, '{8'd0,   8'd255, 8'd0,   8'd0,   1'b1}},
      '{16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b1, '{8'd255, 8'd255, 8'd254, 8'd128, 1'b1}},
      // One lit count at the dark level disables the ratio.
      '{16'hFFFF, 16'h0000, 16'h0000, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd0,   1'b0}},
      '{16'h0000, 16'hFFFF, 16'h0000, 1'b1, '{8'd0,   8'd255, 8'd0,   8'd0,   1'b0}},
      '{16'hAAAA, 16'h5555, 16'h0000, 1'b0, '0},
      '{16'h5555, 16'hAAAA, 16'h0000, 1'b0, '0},
      '{16'h8000, 16'h4000, 16'h2000, 1'b0, '0},
      '{16'h1234, 16'h1234, 16'h1233, 1'b0, '0},
      // Ratio exactly at the clamp limit, then a ratio of one half and count_a below the dark count.
      '{16'h0003, 16'h0002, 16'h0001, 1'b0, '0},
      '{16'h8001, 16'h4001, 16'h0001, 1'b0, '0},
      '{16'hFFFE, 16'hFFFF, 16'hFFFD, 1'b0, '0},
      '{16'h0005, 16'h0300, 16'h0010, 1'b0, '0}
    };

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_cases[i]) begin
      want = dir_cases[i].typed ? dir_cases[i].want
           : normalize_pixel(dir_cases[i].ca, dir_cases[i].cb, dir_cases[i].cc);
      send_pixel({dir_cases[i].cc, dir_cases[i].cb, dir_cases[i].ca}, want);
    end

    for (int p = 0; p < PHASES; p++) begin
      in_tvalid <= 1'b0;
      steady = 1'b0;
      while (normalized_pixels.size() != 0) @(negedge clk);
      case (p)
        0: apply_settings(LAYERS_ONE, 16'd1, COUNT_TOP, COUNT_TOP);
        1: apply_settings(LAYERS_TWO, 16'd0, 16'd255, COUNT_TOP);
        2: apply_settings(2'd0, COUNT_TOP, 16'd0, 16'd1);
        3: apply_settings(LAYERS_FULL, 16'd255, 16'd1000, 16'd0);
        STEADY_PHASE: apply_settings(LAYERS_FULL, COUNT_TOP, COUNT_TOP, COUNT_TOP);
        default: apply_settings(2'($urandom_range(0, 3)), pick_max(), pick_max(), pick_max());
      endcase
      steady = (p == STEADY_PHASE);
      repeat (PIXELS_PER_PHASE) begin
        logic [IN_TDATA_W-1:0] pixel;
        pixel = draw_pixel();
        send_pixel(pixel, normalize_pixel(pixel[FIELD_W-1:0], pixel[2*FIELD_W-1:FIELD_W],
                                          pixel[3*FIELD_W-1:2*FIELD_W]));
      end
    end

    // Drain the pipeline, then give stray results time to show up.
    in_tvalid <= 1'b0;
    steady = 1'b0;
    for (int n = 0; n < 5000 && normalized_pixels.size() != 0; n++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (normalized_pixels.size() != 0) begin
      $error("%0d pixels never produced a result", normalized_pixels.size());
      bad_fields++;
    end
    if (bad_fields == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Hard stop in case the stream hangs.
  initial begin
    #400000;
    $display("testbench: errors");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/cpnt_pkg.sv
rtl/cpnt_front.sv
rtl/cpnt_cell.sv
rtl/camera_pixel_normalize_transmission_unit.sv
rtl/cpnt_checker.sv
dv/testbench.sv
